FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define BCL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that a condition holds in the cycle after its trigger
`define BCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/bcl_pkg.sv
`default_nettype none

package bcl_pkg;

   // Sizing
   localparam int CODE_LENGTH    = 4;
   localparam int TIMER_BITS     = 26;
   localparam int CFG_BITS       = 26;
   localparam int DIGIT_BITS     = 4;
   localparam int NUM_CODE_REGS  = 4;
   localparam int CODE_BITS      = 14;
   localparam int CURSOR_BITS    = (CODE_LENGTH > 2) ? $clog2(CODE_LENGTH) : 1;
   localparam int CMP_BITS       = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
   localparam int REG_INDEX_BITS = 3;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 24;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   // Reset values of the configuration registers
   localparam logic [CFG_BITS-1:0] LOCKOUT_RESET = CFG_BITS'(500000);
   localparam logic [CFG_BITS-1:0] HOLD_RESET    = CFG_BITS'(4000000);
   localparam logic [NUM_CODE_REGS-1:0][DIGIT_BITS-1:0] CODE_RESET = {
      DIGIT_BITS'(8), DIGIT_BITS'(8), DIGIT_BITS'(4), DIGIT_BITS'(1)
   };

   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_PRESS = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      BTN_DOWN  = 2'd0,
      BTN_UP    = 2'd1,
      BTN_NEXT  = 2'd2,
      BTN_CHECK = 2'd3
   } button_type;

   typedef enum logic [1:0] {
      VERDICT_NONE    = 2'd0,
      VERDICT_GRANTED = 2'd1,
      VERDICT_DENIED  = 2'd2
   } verdict_type;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_CODE_0  = 3'd0,
      REG_CODE_1  = 3'd1,
      REG_CODE_2  = 3'd2,
      REG_CODE_3  = 3'd3,
      REG_LOCKOUT = 3'd4,
      REG_HOLD    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [NUM_CODE_REGS-1:0][DIGIT_BITS-1:0] code_digit;
      logic [CFG_BITS-1:0]                      lockout_ticks;
      logic [CFG_BITS-1:0]                      denied_hold_ticks;
   } cfg_type;

   typedef struct packed {
      command_type command;
      button_type  button;
   } item_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] entered_code;
      logic [1:0]           cursor_position;
      logic                 press_accepted;
      verdict_type          verdict;
      logic                 granted_lamp;
      logic                 denied_lamp;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/button_code_lock.sv
// An accepted word goes through the input register, then the result register, to rsp.
// Throughput: one word per cycle; the input register and the result register each
// advance whenever the next one is empty or being drained.
// Reset (synchronous, active high) clears the entered digits, cursor, counters and
// lamps, and loads the configuration registers with their default values.
`default_nettype none
`include "assert_macros.svh"

module button_code_lock (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bcl_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // [1:0] button, [7:2] zero
   input  logic                                req_tuser,  // [0] command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [13:0] entered_code, [15:14] cursor_position, [16] press_accepted,
   // [18:17] verdict, [19] granted_lamp, [20] denied_lamp, [23:21] zero
   output logic [bcl_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_we,
   input  logic [bcl_pkg::REG_INDEX_BITS-1:0]  csr_index,
   input  logic [bcl_pkg::CFG_BITS-1:0]        csr_wdata
);
   import bcl_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       req_take;
   logic       advance;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_CODE_0:  cfg_in.code_digit[0]     = csr_wdata[DIGIT_BITS-1:0];
            REG_CODE_1:  cfg_in.code_digit[1]     = csr_wdata[DIGIT_BITS-1:0];
            REG_CODE_2:  cfg_in.code_digit[2]     = csr_wdata[DIGIT_BITS-1:0];
            REG_CODE_3:  cfg_in.code_digit[3]     = csr_wdata[DIGIT_BITS-1:0];
            REG_LOCKOUT: cfg_in.lockout_ticks     = csr_wdata;
            REG_HOLD:    cfg_in.denied_hold_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_digit        <= CODE_RESET;
         cfg_ff.lockout_ticks     <= LOCKOUT_RESET;
         cfg_ff.denied_hold_ticks <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline flow: process the held word when the result register can take it
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the incoming word
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.command <= command_type'(req_tuser);
         in_item_ff.button  <= button_type'(req_tdata[1:0]);
      end
   end

   bcl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.denied_lamp, rsp_ff.granted_lamp, rsp_ff.verdict,
                        rsp_ff.press_accepted, rsp_ff.cursor_position,
                        rsp_ff.entered_code};

   `BCL_ASSERT_NEXT(a_stalled_word_held, clock, reset,
                    in_valid_ff && rsp_valid_ff && !rsp_tready,
                    in_valid_ff && $stable(in_item_ff))

endmodule

`default_nettype wire

FILE: rtl/bcl_core.sv
`default_nettype none
`include "assert_macros.svh"

module bcl_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  bcl_pkg::item_type   item,
   input  bcl_pkg::cfg_type    cfg,
   output bcl_pkg::result_type result
);
   import bcl_pkg::*;

   logic [CODE_LENGTH-1:0][DIGIT_BITS-1:0] digits_ff, digits_in;
   logic [DIGIT_BITS-1:0]                  running_ff, running_in;
   logic [CURSOR_BITS-1:0]                 cursor_ff, cursor_in;
   logic [TIMER_BITS-1:0]                  since_press_ff, since_press_in;
   logic [TIMER_BITS-1:0]                  since_lamp_ff, since_lamp_in;
   logic                                   granted_ff, granted_in;
   logic                                   denied_ff, denied_in;

   logic [CODE_LENGTH-1:0][DIGIT_BITS-1:0] secret;
   logic [CODE_LENGTH-1:0]                 digit_equal;
   logic                                   code_match;
   logic                                   accepted;
   logic                                   is_tick;
   logic [TIMER_BITS-1:0]                  press_bumped;
   logic [TIMER_BITS-1:0]                  lamp_bumped;
   logic [CODE_BITS-1:0]                   shown;
   verdict_type                            verdict;

   // Positions past the configured digits compare against zero
   for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_secret
      if (i < NUM_CODE_REGS) begin : g_reg
         assign secret[i] = cfg.code_digit[i];
      end else begin : g_zero
         assign secret[i] = '0;
      end
      assign digit_equal[i] = (digits_ff[i] == secret[i]);
   end

   assign code_match = &digit_equal;
   assign is_tick    = (item.command == CMD_TICK);
   assign accepted   = !is_tick
                       && (CMP_BITS'(since_press_ff) > CMP_BITS'(cfg.lockout_ticks));

   // Saturating tick counters
   assign press_bumped = (since_press_ff == TIMER_MAX) ? TIMER_MAX
                                                       : since_press_ff + 1'b1;
   assign lamp_bumped  = (since_lamp_ff == TIMER_MAX) ? TIMER_MAX
                                                      : since_lamp_ff + 1'b1;

   // Next state for one item
   always_comb begin
      digits_in      = digits_ff;
      running_in     = running_ff;
      cursor_in      = cursor_ff;
      since_press_in = since_press_ff;
      since_lamp_in  = since_lamp_ff;
      granted_in     = granted_ff;
      denied_in      = denied_ff;
      verdict        = VERDICT_NONE;
      if (step) begin
         if (is_tick) begin
            since_press_in = press_bumped;
            since_lamp_in  = lamp_bumped;
            if (denied_ff && (CMP_BITS'(lamp_bumped) > CMP_BITS'(cfg.denied_hold_ticks))) begin
               denied_in = 1'b0;
            end
         end else if (accepted) begin
            since_press_in = '0;
            unique case (item.button)
               BTN_DOWN: begin
                  running_in = (running_ff != '0) ? running_ff - 1'b1 : running_ff;
                  digits_in[cursor_ff] = running_in;
               end
               BTN_UP: begin
                  running_in = (running_ff >= DIGIT_BITS'(9)) ? '0 : running_ff + 1'b1;
                  digits_in[cursor_ff] = running_in;
               end
               BTN_NEXT: begin
                  cursor_in = (cursor_ff == CURSOR_BITS'(CODE_LENGTH - 1)) ? '0
                                                                           : cursor_ff + 1'b1;
               end
               BTN_CHECK: begin
                  if (code_match) begin
                     verdict    = VERDICT_GRANTED;
                     granted_in = 1'b1;
                  end else begin
                     verdict       = VERDICT_DENIED;
                     denied_in     = 1'b1;
                     since_lamp_in = '0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Fold the updated digits into a decimal number, first digit most significant
   always_comb begin
      shown = '0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         shown = CODE_BITS'(shown * CODE_BITS'(10) + CODE_BITS'(digits_in[i]));
      end
   end

   always_comb begin
      result.entered_code    = shown;
      result.cursor_position = 2'(cursor_in);
      result.press_accepted  = accepted;
      result.verdict         = verdict;
      result.granted_lamp    = granted_in;
      result.denied_lamp     = denied_in;
   end

   // Lock state
   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff      <= '0;
         running_ff     <= '0;
         cursor_ff      <= '0;
         since_press_ff <= '0;
         since_lamp_ff  <= '0;
         granted_ff     <= 1'b0;
         denied_ff      <= 1'b0;
      end else begin
         digits_ff      <= digits_in;
         running_ff     <= running_in;
         cursor_ff      <= cursor_in;
         since_press_ff <= since_press_in;
         since_lamp_ff  <= since_lamp_in;
         granted_ff     <= granted_in;
         denied_ff      <= denied_in;
      end
   end

   `BCL_ASSERT_NEXT(a_granted_sticks, clock, reset, granted_ff, granted_ff)
   `BCL_ASSERT_NEXT(a_denied_restarts, clock, reset,
                    step && (verdict == VERDICT_DENIED),
                    denied_ff && (since_lamp_ff == '0))
   `BCL_ASSERT_NEXT(a_rejected_press_inert, clock, reset,
                    step && !is_tick && !accepted,
                    $stable(digits_ff) && $stable(cursor_ff) && $stable(running_ff))

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import bcl_pkg::*;

   localparam int LIMIT_CYCLES = 300000;
   localparam int HOLD_OFF_CYCLES = 300;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;   // [1:0] button, [7:2] zero
   logic                      req_tuser = 1'b0; // [0] command
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // [13:0] entered_code, [15:14] cursor_position, [16] press_accepted,
   // [18:17] verdict, [19] granted_lamp, [20] denied_lamp, [23:21] zero
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [REG_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   button_code_lock DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Lock model: configuration copy and state
   logic [NUM_CODE_REGS-1:0][DIGIT_BITS-1:0] model_code = CODE_RESET;
   logic [CFG_BITS-1:0]                      model_lockout = LOCKOUT_RESET;
   logic [CFG_BITS-1:0]                      model_hold = HOLD_RESET;
   logic [CODE_LENGTH-1:0][DIGIT_BITS-1:0]   model_digits = '0;
   logic [DIGIT_BITS-1:0]                    model_run = '0;
   logic [1:0]                               model_cursor = '0;
   logic [TIMER_BITS-1:0]                    model_since_press = '0;
   logic [TIMER_BITS-1:0]                    model_since_lamp = '0;
   logic                                     model_granted = 1'b0;
   logic                                     model_denied = 1'b0;

   // Stimulus and scoreboard storage
   item_type   pending_inputs[$];
   result_type lock_outputs_due[$];
   item_type   offered;
   result_type seen_output;
   result_type due_output;

   // Sequence builder's view of the digit and cursor
   logic [DIGIT_BITS-1:0] gen_digit;
   logic [1:0]            gen_cursor;
   int                    gen_spare = 0;

   bit calm = 1'b0;
   bit hold_off_arm = 1'b0;
   bit hold_off_taken = 1'b0;
   int hold_off_left = 0;
   int error_count = 0;
   int reported_errors = 0;
   int cycle_count = 0;

   function automatic logic [TIMER_BITS-1:0] bump_timer(input logic [TIMER_BITS-1:0] c);
      return (c == TIMER_MAX) ? c : c + 1'b1;
   endfunction

   // Advance the lock by one word and return what it should show
   function automatic result_type step_lock(input item_type word);
      result_type outcome;
      logic [1:0] pos;
      int shown;
      outcome.press_accepted = 1'b0;
      outcome.verdict = VERDICT_NONE;
      pos = model_cursor;
      if (word.command == CMD_TICK) begin
         model_since_press = bump_timer(model_since_press);
         model_since_lamp = bump_timer(model_since_lamp);
         if (model_denied && model_since_lamp > model_hold)
            model_denied = 1'b0;
      end else if (model_since_press > model_lockout) begin
         outcome.press_accepted = 1'b1;
         model_since_press = '0;
         case (word.button)
            BTN_DOWN: begin
               if (model_run != 4'd0)
                  model_run = model_run - 4'd1;
               model_digits[pos] = model_run;
            end
            BTN_UP: begin
               model_run = (model_run == 4'd9) ? 4'd0 : model_run + 4'd1;
               model_digits[pos] = model_run;
            end
            BTN_NEXT: model_cursor = pos + 2'd1;
            BTN_CHECK: begin
               if (model_digits == model_code) begin
                  outcome.verdict = VERDICT_GRANTED;
                  model_granted = 1'b1;
               end else begin
                  outcome.verdict = VERDICT_DENIED;
                  model_denied = 1'b1;
                  model_since_lamp = '0;
               end
            end
         endcase
      end
      shown = 0;
      for (int i = 0; i < CODE_LENGTH; i++)
         shown = shown * 10 + int'(model_digits[i]);
      outcome.entered_code = CODE_BITS'(shown);
      outcome.cursor_position = model_cursor;
      outcome.granted_lamp = model_granted;
      outcome.denied_lamp = model_denied;
      return outcome;
   endfunction

   // Driver: predict each accepted word, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            lock_outputs_due.push_back(step_lock(offered));
         if (!req_tvalid || req_tready) begin
            if (pending_inputs.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
               offered = pending_inputs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_BITS'(offered.button);
               req_tuser <= offered.command;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result word, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_output.entered_code = rsp_tdata[13:0];
         seen_output.cursor_position = rsp_tdata[15:14];
         seen_output.press_accepted = rsp_tdata[16];
         seen_output.verdict = verdict_type'(rsp_tdata[18:17]);
         seen_output.granted_lamp = rsp_tdata[19];
         seen_output.denied_lamp = rsp_tdata[20];
         if (lock_outputs_due.size() == 0) begin
            error_count++;
            if (reported_errors < 10) begin
               reported_errors++;
               $display("unexpected result word %h at %0t", rsp_tdata, $realtime);
            end
         end else begin
            due_output = lock_outputs_due.pop_front();
            if (seen_output !== due_output) begin
               error_count++;
               if (reported_errors < 10) begin
                  reported_errors++;
                  $display("mismatch at %0t: code %0d/%0d cursor %0d/%0d accepted %0d/%0d",
                           $realtime, due_output.entered_code, seen_output.entered_code,
                           due_output.cursor_position, seen_output.cursor_position,
                           due_output.press_accepted, seen_output.press_accepted);
                  $display("   verdict %0d/%0d granted %0d/%0d denied %0d/%0d (expected/actual)",
                           due_output.verdict, seen_output.verdict,
                           due_output.granted_lamp, seen_output.granted_lamp,
                           due_output.denied_lamp, seen_output.denied_lamp);
               end
            end
         end
      end
      // Hold off the result side once for a long stretch, else stall at random when not calm
      if (hold_off_arm && !hold_off_taken) begin
         hold_off_taken <= 1'b1;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (hold_off_left != 0)
            hold_off_left <= hold_off_left - 1;
         rsp_tready <= (hold_off_left == 0) && (calm || $urandom_range(99) >= 9);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_inputs.size() != 0 || req_tvalid || lock_outputs_due.size() != 0);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CFG_BITS-1:0] wdata);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      case (idx)
         REG_LOCKOUT: model_lockout = wdata;
         REG_HOLD:    model_hold = wdata;
         default:     model_code[int'(idx)] = wdata[DIGIT_BITS-1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Move off the clock edge and pick up the lock's settled digit and cursor
   task automatic start_fill();
      @(negedge clock);
      gen_digit = model_run;
      gen_cursor = model_cursor;
   endtask

   task automatic add_ticks(input int n);
      item_type word;
      word.command = CMD_TICK;
      repeat (n) begin
         word.button = button_type'($urandom_range(3));
         pending_inputs.push_back(word);
      end
   endtask

   // Press after enough ticks for the lockout to have run out
   task automatic add_press(input button_type btn);
      item_type word;
      add_ticks(int'(model_lockout) + 1 + $urandom_range(gen_spare));
      word.command = CMD_PRESS;
      word.button = btn;
      pending_inputs.push_back(word);
   endtask

   task automatic add_noise(input int n);
      item_type word;
      repeat (n) begin
         word.command = ($urandom_range(99) < 45) ? CMD_PRESS : CMD_TICK;
         word.button = button_type'($urandom_range(3));
         pending_inputs.push_back(word);
      end
   endtask

   // Dial in four digits from the first position, then check them
   task automatic enter_code(input logic [CODE_LENGTH-1:0][DIGIT_BITS-1:0] target);
      while (gen_cursor != 2'd0) begin
         add_press(BTN_NEXT);
         gen_cursor = gen_cursor + 2'd1;
      end
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (target[i] == gen_digit) begin
            // the running digit already fits: step away and back to write it
            if (gen_digit != 4'd0) begin
               add_press(BTN_DOWN);
               add_press(BTN_UP);
            end else begin
               add_press(BTN_UP);
               add_press(BTN_DOWN);
            end
         end else if (target[i] < gen_digit &&
                      (gen_digit - target[i] <= 5 || $urandom_range(1) == 1)) begin
            repeat (gen_digit - target[i]) add_press(BTN_DOWN);
         end else begin
            repeat ((int'(target[i]) + 10 - int'(gen_digit)) % 10) add_press(BTN_UP);
         end
         gen_digit = target[i];
         add_press(BTN_NEXT);
      end
      add_press(BTN_CHECK);
   endtask

   initial begin
      logic [CODE_LENGTH-1:0][DIGIT_BITS-1:0] target;
      item_type word;
      int phase;
      int random_items;
      int pick;
      bit code_reachable;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Defaults: the lockout has not run out, so presses are dropped
      start_fill();
      add_ticks(1);
      word.command = CMD_PRESS;
      word.button = BTN_CHECK;
      pending_inputs.push_back(word);
      word.button = BTN_UP;
      pending_inputs.push_back(word);
      wait_drained();

      // Directed: down at zero, dropped press, mismatch, lamp expiry, relight, grant
      write_reg(REG_LOCKOUT, '0);
      write_reg(REG_HOLD, CFG_BITS'(2));
      write_reg(REG_CODE_0, CFG_BITS'(0));
      write_reg(REG_CODE_1, CFG_BITS'(1));
      write_reg(REG_CODE_2, CFG_BITS'(0));
      write_reg(REG_CODE_3, CFG_BITS'(0));
      start_fill();
      add_press(BTN_DOWN);
      word.command = CMD_PRESS;
      word.button = BTN_UP;
      pending_inputs.push_back(word);
      add_press(BTN_UP);
      add_press(BTN_CHECK);
      add_ticks(3);
      add_press(BTN_CHECK);
      add_press(BTN_CHECK);
      add_press(BTN_DOWN);
      add_press(BTN_NEXT);
      add_press(BTN_UP);
      add_press(BTN_CHECK);
      wait_drained();

      // Longest hold with a digit that never matches: the denied lamp stays lit
      write_reg(REG_HOLD, {CFG_BITS{1'b1}});
      write_reg(REG_CODE_3, CFG_BITS'(15));
      start_fill();
      gen_spare = 2;
      for (int i = 0; i < CODE_LENGTH; i++)
         target[i] = DIGIT_BITS'($urandom_range(9));
      enter_code(target);
      add_ticks(20);
      add_noise(20);
      wait_drained();

      // Longest lockout: every press is dropped; zero hold clears the lamp
      write_reg(REG_LOCKOUT, {CFG_BITS{1'b1}});
      write_reg(REG_HOLD, '0);
      start_fill();
      add_noise(40);
      wait_drained();

      // Random phases: mostly full code entries, some noise at the end
      random_items = 0;
      phase = 0;
      while (random_items < 1300 || phase < 4) begin
         for (int k = 0; k < NUM_CODE_REGS; k++)
            if (phase == 0 || $urandom_range(1) == 1)
               write_reg(reg_index_type'(k), CFG_BITS'($urandom_range(9)));
         write_reg(REG_LOCKOUT,
                   CFG_BITS'((phase % 4 == 3) ? $urandom_range(7, 4) : $urandom_range(2)));
         if (phase == 0 || $urandom_range(1) == 1)
            write_reg(REG_HOLD, CFG_BITS'($urandom_range(40)));
         start_fill();
         calm = (phase == 1);
         if (phase == 3)
            hold_off_arm = 1'b1;
         code_reachable = 1'b1;
         for (int i = 0; i < CODE_LENGTH; i++)
            if (model_code[i] > 4'd9)
               code_reachable = 1'b0;
         repeat ($urandom_range(3, 1)) begin
            pick = code_reachable ? $urandom_range(2) : 2;
            target = model_code;
            if (pick == 1)
               target[$urandom_range(3)] = DIGIT_BITS'($urandom_range(9));
            else if (pick == 2)
               for (int i = 0; i < CODE_LENGTH; i++)
                  target[i] = DIGIT_BITS'($urandom_range(9));
            enter_code(target);
            add_ticks($urandom_range(5));
         end
         add_noise($urandom_range(40, 10));
         random_items += pending_inputs.size();
         wait_drained();
         phase++;
      end
      calm = 1'b0;

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
